// ===== hdl/svd_pkg.sv =====
// Shared types and constants of the VT52 screen-difference encoder.
// No dependencies.
`timescale 1ns / 1ps
package svd_pkg;

  localparam int DefRows = 24;
  localparam int DefCols = 80;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_Y   = 8'h59;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_M   = 8'h4D;
  localparam logic [7:0] CH_L   = 8'h4C;
  localparam logic [7:0] CH_P   = 8'h70;
  localparam logic [7:0] CH_Q   = 8'h71;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_LE  = 8'h65;
  localparam logic [7:0] CH_LF  = 8'h66;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_SCROLL = 2'd1,
    REQ_CELL   = 2'd2,
    REQ_FINISH = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    SEL_ESC, SEL_E, SEL_Q, SEL_U, SEL_SHOW, SEL_REV, SEL_BOLD,
    SEL_Y, SEL_ROW, SEL_COL, SEL_LINE, SEL_CHAR, SEL_VIS
  } sel_t;

  // emission phases, in send order
  localparam int NumPh = 9;
  localparam logic [3:0] PH_INIT  = 4'd0;
  localparam logic [3:0] PH_REV1  = 4'd1;
  localparam logic [3:0] PH_BOLD1 = 4'd2;
  localparam logic [3:0] PH_GOTO  = 4'd3;
  localparam logic [3:0] PH_REV2  = 4'd4;
  localparam logic [3:0] PH_BOLD2 = 4'd5;
  localparam logic [3:0] PH_LINE  = 4'd6;
  localparam logic [3:0] PH_CHAR  = 4'd7;
  localparam logic [3:0] PH_VIS   = 4'd8;

  typedef struct packed {
    logic capture;
    logic read;
    logic plan;
    logic walk_start;
    logic walk_blank;
    logic walk_read;
    logic walk_write;
    logic emit;
    sel_t sel;
    logic last;
  } svd_cmd_t;

  typedef struct packed {
    logic [NumPh-1:0] en;
    logic             walk;
    logic [4:0]       lines;
    logic             out_free;
    logic             walk_last;
  } svd_sts_t;

endpackage

// ===== hdl/svd_dp.sv =====
// Datapath: request capture, shadow memory and its walker, tracked console
// state and the output byte register. Depends on svd_pkg.
`timescale 1ns / 1ps
module svd_dp #(
  parameter int ROWS = svd_pkg::DefRows,
  parameter int COLS = svd_pkg::DefCols
) (
  input  logic              clk,
  input  logic              rst,
  input  svd_pkg::svd_cmd_t cmd,
  output svd_pkg::svd_sts_t sts,
  input  logic [1:0]        req_type,
  input  logic signed [5:0] scroll_amount,
  input  logic [4:0]        cell_row,
  input  logic [6:0]        cell_col,
  input  logic [7:0]        cell_char,
  input  logic [1:0]        cell_attr,
  input  logic [4:0]        cursor_row,
  input  logic [7:0]        cursor_col,
  input  logic              cursor_visible,
  input  logic              byte_ready,
  output logic              byte_valid,
  output logic [7:0]        out_byte,
  output logic              last_byte
);
  import svd_pkg::*;

  localparam int N  = ROWS * COLS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int SW = $clog2(2 * N + 1);
  localparam int IW = $clog2(32 * COLS + 128);
  localparam logic [9:0] BLANK = {2'b00, CH_SP};

  logic [9:0] mem [N];
  logic [9:0] rdata;

  req_t       q_type;
  logic       q_up, q_nz, q_on, q_vis;
  logic [4:0] q_n, q_row, q_crow;
  logic [6:0] q_col;
  logic [7:0] q_char, q_ccol;
  logic [1:0] q_attr;
  logic [IW-1:0] idx;
  logic [SW-1:0] off;

  logic [4:0] track_row;
  logic [6:0] track_col;
  logic       track_valid, shown_flag;
  logic [1:0] active_attr;

  logic [NumPh-1:0] en;
  logic       walk;
  logic [1:0] tgt;
  logic [4:0] goto_row;
  logic [6:0] goto_col;

  logic [AW-1:0] wdst;
  logic          wup, wblank;

  logic [5:0] raw, mag;
  logic [4:0] n_in;
  logic       up_in;
  logic [SW-1:0] src_sum, src;
  logic       copy_ok;
  logic [AW-1:0] raddr;
  logic       we;
  logic [AW-1:0] waddr;
  logic [9:0] wdata;

  logic       cell_go, scr_go, fin, ini, cel;
  logic [1:0] tgt_c, dif;
  logic [6:0] ccol_cl;
  logic [NumPh-1:0] en_c;
  logic [7:0] col_inc;
  logic [7:0] byte_c;

  assign raw   = scroll_amount;
  assign up_in = (raw != 6'd0) && !raw[5];
  assign mag   = up_in ? raw : 6'(-raw);
  assign n_in  = (mag > 6'(ROWS)) ? 5'(ROWS) : mag[4:0];

  always_comb begin
    src_sum = SW'(wdst) + off;
    if (wblank) begin
      copy_ok = 1'b0;
      src     = src_sum;
    end else if (wup) begin
      copy_ok = src_sum < SW'(N);
      src     = src_sum;
    end else begin
      copy_ok = SW'(wdst) >= off;
      src     = SW'(wdst) - off;
    end
  end

  assign ini = (q_type == REQ_INIT);
  assign fin = (q_type == REQ_FINISH);
  assign cel = (q_type == REQ_CELL);
  assign scr_go  = (q_type == REQ_SCROLL) && q_nz;
  assign cell_go = cel && q_on && (rdata != {q_attr, q_char});
  assign tgt_c   = cel ? q_attr : 2'b00;
  assign dif     = tgt_c ^ active_attr;
  assign ccol_cl = (q_ccol >= 8'(COLS)) ? 7'(COLS - 1) : q_ccol[6:0];
  assign col_inc = {1'b0, q_col} + 8'd1;

  always_comb begin
    en_c = '0;
    en_c[PH_INIT]  = ini;
    en_c[PH_REV1]  = (scr_go || fin) && dif[0];
    en_c[PH_BOLD1] = (scr_go || fin) && dif[1];
    en_c[PH_GOTO]  = ini || scr_go || fin ||
                     (cell_go && (!track_valid || track_row != q_row || track_col != q_col));
    en_c[PH_REV2]  = cell_go && dif[0];
    en_c[PH_BOLD2] = cell_go && dif[1];
    en_c[PH_LINE]  = scr_go;
    en_c[PH_CHAR]  = cell_go;
    en_c[PH_VIS]   = fin && (q_vis != shown_flag);
  end

  assign raddr = cmd.walk_read ? src[AW-1:0] : (q_on ? idx[AW-1:0] : '0);
  assign we    = cmd.walk_write || (cmd.plan && cell_go);
  assign waddr = cmd.walk_write ? wdst : idx[AW-1:0];
  assign wdata = cmd.walk_write ? (copy_ok ? rdata : BLANK) : {q_attr, q_char};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.read || cmd.walk_read) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_type <= req_t'(req_type);
      q_up   <= up_in;
      q_nz   <= (raw != 6'd0);
      q_n    <= n_in;
      q_row  <= cell_row;
      q_col  <= cell_col;
      q_char <= cell_char;
      q_attr <= cell_attr;
      q_crow <= cursor_row;
      q_ccol <= cursor_col;
      q_vis  <= cursor_visible;
      q_on   <= (cell_row < 5'(ROWS)) && ({1'b0, cell_col} < 8'(COLS));
      idx    <= IW'(cell_row * COLS + cell_col);
    end
    if (cmd.read) off <= SW'(q_n * COLS);
    if (cmd.plan) begin
      tgt      <= tgt_c;
      goto_row <= cel ? q_row : (fin ? q_crow : 5'd0);
      goto_col <= cel ? q_col : (fin ? ccol_cl : 7'd0);
    end
    if (cmd.walk_start) begin
      wblank <= cmd.walk_blank;
      wup    <= cmd.walk_blank || q_up;
      wdst   <= (cmd.walk_blank || q_up) ? '0 : AW'(N - 1);
    end else if (cmd.walk_write) begin
      wdst <= wup ? wdst + AW'(1) : wdst - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_row   <= '0;
      track_col   <= '0;
      track_valid <= 1'b0;
      active_attr <= '0;
      shown_flag  <= 1'b1;
      en          <= '0;
      walk        <= 1'b0;
    end else if (cmd.plan) begin
      en   <= en_c;
      walk <= ini || scr_go;
      if (ini || scr_go) begin
        active_attr <= '0;
        track_row   <= '0;
        track_col   <= '0;
        track_valid <= 1'b1;
        if (ini) shown_flag <= 1'b1;
      end else if (cell_go) begin
        active_attr <= q_attr;
        track_row   <= q_row;
        if (col_inc < 8'(COLS)) begin
          track_col   <= col_inc[6:0];
          track_valid <= 1'b1;
        end else begin
          track_col   <= q_col;
          track_valid <= 1'b0;
        end
      end else if (fin) begin
        active_attr <= '0;
        track_row   <= q_crow;
        track_col   <= ccol_cl;
        track_valid <= 1'b1;
        shown_flag  <= q_vis;
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_ESC:  byte_c = CH_ESC;
      SEL_E:    byte_c = CH_E;
      SEL_Q:    byte_c = CH_Q;
      SEL_U:    byte_c = CH_U;
      SEL_SHOW: byte_c = CH_LE;
      SEL_REV:  byte_c = tgt[0] ? CH_P : CH_Q;
      SEL_BOLD: byte_c = tgt[1] ? CH_R : CH_U;
      SEL_Y:    byte_c = CH_Y;
      SEL_ROW:  byte_c = {3'b000, goto_row} + CH_SP;
      SEL_COL:  byte_c = {1'b0, goto_col} + CH_SP;
      SEL_LINE: byte_c = q_up ? CH_M : CH_L;
      SEL_CHAR: byte_c = q_char;
      SEL_VIS:  byte_c = q_vis ? CH_LE : CH_LF;
      default:  byte_c = CH_ESC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (cmd.emit) begin
      byte_valid <= 1'b1;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_byte  <= byte_c;
      last_byte <= cmd.last;
    end
  end

  assign sts.en        = en;
  assign sts.walk      = walk;
  assign sts.lines     = q_n;
  assign sts.out_free  = !byte_valid || byte_ready;
  assign sts.walk_last = wup ? (wdst == AW'(N - 1)) : (wdst == '0);

endmodule

// ===== hdl/svd_ctrl.sv =====
// Controller: sequences request handling, byte phases and the shadow walk.
// Depends on svd_pkg.
`timescale 1ns / 1ps
module svd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  svd_pkg::svd_sts_t sts,
  output svd_pkg::svd_cmd_t cmd
);
  import svd_pkg::*;

  typedef enum logic [3:0] {
    S_RST, S_IDLE, S_READ, S_PLAN, S_PICK, S_EMIT, S_WSTART, S_WRD, S_WWR
  } state_t;

  state_t     state;
  logic [3:0] ph;
  logic [5:0] cnt;

  logic [3:0] first_ph, next_ph;
  logic       any_next;
  logic [5:0] ph_len;
  logic       ph_end;
  sel_t       sel_c;

  always_comb begin
    first_ph = '0;
    next_ph  = '0;
    any_next = 1'b0;
    for (int i = NumPh - 1; i >= 0; i--) begin
      if (sts.en[i]) first_ph = 4'(i);
      if (sts.en[i] && 4'(i) > ph) begin
        next_ph  = 4'(i);
        any_next = 1'b1;
      end
    end
  end

  always_comb begin
    case (ph)
      PH_INIT: ph_len = 6'd7;
      PH_GOTO: ph_len = 6'd3;
      PH_LINE: ph_len = {sts.lines, 1'b0} - 6'd1;
      PH_CHAR: ph_len = 6'd0;
      default: ph_len = 6'd1;
    endcase
  end
  assign ph_end = (cnt == ph_len);

  always_comb begin
    case (ph)
      PH_INIT: begin
        if (!cnt[0]) sel_c = SEL_ESC;
        else begin
          case (cnt[2:1])
            2'd0:    sel_c = SEL_E;
            2'd1:    sel_c = SEL_Q;
            2'd2:    sel_c = SEL_U;
            default: sel_c = SEL_SHOW;
          endcase
        end
      end
      PH_REV1, PH_REV2:   sel_c = cnt[0] ? SEL_REV : SEL_ESC;
      PH_BOLD1, PH_BOLD2: sel_c = cnt[0] ? SEL_BOLD : SEL_ESC;
      PH_GOTO: begin
        case (cnt[1:0])
          2'd0:    sel_c = SEL_ESC;
          2'd1:    sel_c = SEL_Y;
          2'd2:    sel_c = SEL_ROW;
          default: sel_c = SEL_COL;
        endcase
      end
      PH_LINE: sel_c = cnt[0] ? SEL_LINE : SEL_ESC;
      PH_CHAR: sel_c = SEL_CHAR;
      PH_VIS:  sel_c = cnt[0] ? SEL_VIS : SEL_ESC;
      default: sel_c = SEL_ESC;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.sel        = sel_c;
    cmd.last       = ph_end && !any_next;
    cmd.capture    = (state == S_IDLE) && req_valid;
    cmd.read       = (state == S_READ);
    cmd.plan       = (state == S_PLAN);
    cmd.walk_start = (state == S_RST) || (state == S_WSTART);
    cmd.walk_blank = (state == S_RST) || sts.en[PH_INIT];
    cmd.walk_read  = (state == S_WRD);
    cmd.walk_write = (state == S_WWR);
    cmd.emit       = (state == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST;
      ph    <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_RST:  state <= S_WRD;
        S_IDLE: if (req_valid) state <= S_READ;
        S_READ: state <= S_PLAN;
        S_PLAN: state <= S_PICK;
        S_PICK: begin
          ph  <= first_ph;
          cnt <= '0;
          if (sts.en != '0) state <= S_EMIT;
          else              state <= S_IDLE;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if (!ph_end) cnt <= cnt + 6'd1;
            else if (any_next) begin
              ph  <= next_ph;
              cnt <= '0;
            end else begin
              state <= sts.walk ? S_WSTART : S_IDLE;
            end
          end
        end
        S_WSTART: state <= S_WRD;
        S_WRD:    state <= S_WWR;
        S_WWR:    state <= sts.walk_last ? S_IDLE : S_WRD;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/screen_diff_vt52_encoder.sv =====
// Top level of the VT52 screen-difference encoder: controller plus datapath.
// Depends on svd_pkg, svd_ctrl, svd_dp.
//
//   channel | signals                      | direction
//   req     | req_valid/req_ready + fields | in, one request per beat
//   byte    | byte_valid/byte_ready        | out, one console byte per beat
//
// A request is captured, its shadow entry is read (S_READ) and compared
// (S_PLAN) and its first byte phase picked (S_PICK); then one byte is sent
// per cycle while byte_ready holds. Init and nonzero scroll then walk the
// shadow memory, one read and one write per cell. After reset the same walk
// blanks the shadow with req_ready low. A stalled byte beat holds the
// sequence in place.
`timescale 1ns / 1ps
module screen_diff_vt52_encoder #(
  parameter int ROWS = svd_pkg::DefRows,
  parameter int COLS = svd_pkg::DefCols
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_type,
  input  logic signed [5:0] scroll_amount,
  input  logic [4:0]        cell_row,
  input  logic [6:0]        cell_col,
  input  logic [7:0]        cell_char,
  input  logic [1:0]        cell_attr,
  input  logic [4:0]        cursor_row,
  input  logic [7:0]        cursor_col,
  input  logic              cursor_visible,
  output logic              byte_valid,
  input  logic              byte_ready,
  output logic [7:0]        out_byte,
  output logic              last_byte
);
  import svd_pkg::*;

  svd_cmd_t cmd;
  svd_sts_t sts;

  svd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svd_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req_type),
    .scroll_amount  (scroll_amount),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col),
    .cursor_visible (cursor_visible),
    .byte_ready     (byte_ready),
    .byte_valid     (byte_valid),
    .out_byte       (out_byte),
    .last_byte      (last_byte)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!byte_valid || byte_ready))
    else $error("byte loaded over a pending beat");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  a_walk_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_write || cmd.walk_read) |-> (!cmd.emit && !req_ready))
    else $error("shadow walk overlaps other work");

endmodule
